// ----- rtl/rgsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rgsc_pkg
// Shared types and constants of the reference-counted glyph slot cache.
// ----------------------------------------------------------------------------
package rgsc_pkg;

	// Field widths fixed by the request and result formats.
	localparam int KEY_W     = 21;
	localparam int REF_W     = 16;
	localparam int BASE_W    = 12;
	localparam int TILE_W    = 16;
	localparam int SLOTO_W   = 5;
	localparam int LIVEO_W   = 6;
	localparam int ENTRY_W   = KEY_W + REF_W;
	localparam int S_DATA_W  = 40;
	localparam int S_USER_W  = 2;
	localparam int M_DATA_W  = 32;
	localparam int M_USER_W  = 3;

	localparam logic [REF_W-1:0] REF_MAX = '1;

	// Request kinds.
	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_CLEAR   = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_NEW      = 3'd1,
		ST_NO_PAGE  = 3'd2,
		ST_REFUSED  = 3'd3,
		ST_UNMAPPED = 3'd4,
		ST_DONE     = 3'd5,
		ST_IGNORED  = 3'd6,
		ST_SPARE    = 3'd7
	} status_t;

	// One slot as held in the slot memory.
	typedef struct packed {
		logic [REF_W-1:0] refs;
		logic [KEY_W-1:0] key;
	} entry_t;

	// Verdict of the shared compare unit on one slot.
	typedef struct packed {
		logic             hit;
		logic             free;
		logic             live;
		logic             last_ref;
		logic [REF_W-1:0] refs_inc;
		logic [REF_W-1:0] refs_dec;
	} match_t;

endpackage

// ----- rtl/refcounted_glyph_slot_cache_core.sv -----
// ----------------------------------------------------------------------------
// refcounted_glyph_slot_cache_core
// Reference-counted slot cache keyed by codepoint, with slots in pages.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_tready is high only while the block
// is idle. An allocate request scans the open pages one slot per cycle
// through the slot memory and a single compare unit; a hit ends the scan
// early, and while no page is open the scan is skipped. A release reads
// its slot and, if it is live, writes back the lowered count; an allocate
// of key zero or an unknown request goes straight to its result.
// A clear, and likewise the start-up after reset, sweeps the slot memory one
// slot per cycle through all SLOTS_PER_PAGE * MAX_PAGES slots, during which
// no request is accepted. A finished result waits in the output register
// while the next request is already being accepted and worked on.
// ----------------------------------------------------------------------------
module refcounted_glyph_slot_cache_core #(
	parameter int SLOTS_PER_PAGE = 16,
	parameter int MAX_PAGES      = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request channel.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata, lowest bit first: codepoint[20:0], slot_select[25:21],
	// glyph_mapped[26], page_available[27], new_page_base[39:28].
	input  logic [rgsc_pkg::S_DATA_W-1:0]   s_tdata,
	// s_tuser: req_type[1:0].
	input  logic [rgsc_pkg::S_USER_W-1:0]   s_tuser,
	// Result channel.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, lowest bit first: tile_index[15:0], slot_number[20:16],
	// load_needed[21], live_slots[27:22], zero[31:28].
	output logic [rgsc_pkg::M_DATA_W-1:0]   m_tdata,
	// m_tuser: status[2:0].
	output logic [rgsc_pkg::M_USER_W-1:0]   m_tuser
);

	localparam int NSLOTS = SLOTS_PER_PAGE * MAX_PAGES;
	localparam int SW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
	localparam int OW     = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
	localparam int PW     = $clog2(MAX_PAGES + 1);
	localparam int PIW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int LW     = $clog2(NSLOTS + 1);

	typedef enum logic [5:0] {
		SQ_CLR   = 6'b000001,
		SQ_IDLE  = 6'b000010,
		SQ_SCAN  = 6'b000100,
		SQ_ALLOC = 6'b001000,
		SQ_REL   = 6'b010000,
		SQ_DONE  = 6'b100000
	} state_t;

	// Request fields.
	logic [1:0]                    in_req;
	logic [rgsc_pkg::KEY_W-1:0]    in_cp;
	logic [4:0]                    in_slot;
	logic                          in_mapped;
	logic                          in_avail;
	logic [rgsc_pkg::BASE_W-1:0]   in_base;
	logic                          accept;
	logic                          slot_in_range;

	assign in_req    = s_tuser[1:0];
	assign in_cp     = s_tdata[20:0];
	assign in_slot   = s_tdata[25:21];
	assign in_mapped = s_tdata[26];
	assign in_avail  = s_tdata[27];
	assign in_base   = s_tdata[39:28];

	// Sequencer and request registers.
	state_t                        state_q;
	logic                          clr_report_q;
	logic [SW-1:0]                 scan_addr_q;
	logic [PW-1:0]                 page_q;
	logic [OW-1:0]                 off_q;
	logic                          issue_q;
	logic [PW-1:0]                 open_q;
	logic [LW-1:0]                 live_q;
	logic [rgsc_pkg::BASE_W-1:0]   page_base_q [MAX_PAGES];
	logic [rgsc_pkg::KEY_W-1:0]    cp_q;
	logic                          mapped_q;
	logic                          avail_q;
	logic [rgsc_pkg::BASE_W-1:0]   nbase_q;
	logic [SW-1:0]                 rel_addr_q;

	// Compare stage, which follows the memory address by one register.
	logic                          vld_s1;
	logic                          last_s1;
	logic [SW-1:0]                 addr_s1;
	logic [PIW-1:0]                page_s1;
	logic [OW-1:0]                 off_s1;

	// Best candidate of the scan.
	logic                          hit_q;
	logic                          free_q;
	logic [SW-1:0]                 fnd_addr_q;
	logic [PIW-1:0]                fnd_page_q;
	logic [OW-1:0]                 fnd_off_q;
	logic [rgsc_pkg::REF_W-1:0]    fnd_refs_q;

	// Pending result.
	rgsc_pkg::status_t             res_status_q;
	logic [SW-1:0]                 res_slot_q;
	logic [PIW-1:0]                res_page_q;
	logic [OW-1:0]                 res_off_q;
	logic                          res_load_q;

	// Output register.
	logic                          m_tvalid_q;
	logic [rgsc_pkg::M_DATA_W-1:0] m_tdata_q;
	logic [rgsc_pkg::M_USER_W-1:0] m_tuser_q;

	// Slot memory and compare unit.
	logic                          ram_we;
	logic [SW-1:0]                 ram_waddr;
	rgsc_pkg::entry_t              ram_wdata;
	logic [SW-1:0]                 ram_raddr;
	rgsc_pkg::entry_t              ram_rdata;
	rgsc_pkg::match_t              verdict;

	logic                          issue_wrap;
	logic                          issue_last;
	logic                          res_has_tile;
	logic [rgsc_pkg::TILE_W-1:0]   tile_calc;
	logic                          out_free;

	assign s_tready      = (state_q == SQ_IDLE);
	assign accept        = s_tvalid && s_tready;
	assign slot_in_range = (32'(in_slot) < NSLOTS);
	assign out_free      = !m_tvalid_q || m_tready;

	assign issue_wrap = (off_q == OW'(SLOTS_PER_PAGE - 1));
	assign issue_last = issue_wrap && ((page_q + PW'(1)) == open_q);

	rgsc_ram #(
		.WIDTH (rgsc_pkg::ENTRY_W),
		.DEPTH (NSLOTS),
		.AW    (SW)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rgsc_match u_match (
		.entry     (ram_rdata),
		.codepoint (cp_q),
		.verdict   (verdict)
	);

	// Memory read address: the scan pointer while scanning, else the
	// release slot so that its entry is ready in the following cycle.
	assign ram_raddr = (state_q == SQ_SCAN) ? scan_addr_q : SW'(in_slot);

	// Memory writes: clearing sweep, count updates and slot fills.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = scan_addr_q;
		ram_wdata = '0;
		unique case (state_q)
			SQ_CLR: begin
				ram_we = 1'b1;
			end
			SQ_ALLOC: begin
				if (hit_q) begin
					ram_we         = 1'b1;
					ram_waddr      = fnd_addr_q;
					ram_wdata.key  = cp_q;
					ram_wdata.refs = fnd_refs_q;
				end else if (mapped_q &&
						(free_q || ((32'(open_q) < MAX_PAGES) && avail_q))) begin
					ram_we         = 1'b1;
					ram_waddr      = free_q ? fnd_addr_q : scan_addr_q;
					ram_wdata.key  = cp_q;
					ram_wdata.refs = rgsc_pkg::REF_W'(1);
				end
			end
			SQ_REL: begin
				ram_we         = verdict.live;
				ram_waddr      = rel_addr_q;
				ram_wdata.key  = verdict.last_ref ? '0 : ram_rdata.key;
				ram_wdata.refs = verdict.refs_dec;
			end
			SQ_IDLE, SQ_SCAN, SQ_DONE: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Tile of the pending result.
	assign res_has_tile = (res_status_q == rgsc_pkg::ST_HIT) ||
		(res_status_q == rgsc_pkg::ST_NEW);
	assign tile_calc = rgsc_pkg::TILE_W'((32'(page_base_q[res_page_q]) * SLOTS_PER_PAGE)
		+ 32'(res_off_q));

	// Page base table; only open pages are ever read.
	always_ff @(posedge clk) begin
		if ((state_q == SQ_ALLOC) && !hit_q && !free_q &&
				(32'(open_q) < MAX_PAGES) && avail_q) begin
			page_base_q[open_q[PIW-1:0]] <= nbase_q;
		end
	end

	// Request capture, compare stage and scan candidate.
	always_ff @(posedge clk) begin
		if (accept) begin
			cp_q       <= in_cp;
			mapped_q   <= in_mapped;
			avail_q    <= in_avail;
			nbase_q    <= in_base;
			rel_addr_q <= SW'(in_slot);
		end
		addr_s1 <= scan_addr_q;
		page_s1 <= page_q[PIW-1:0];
		off_s1  <= off_q;
		last_s1 <= issue_last;
		if ((state_q == SQ_SCAN) && vld_s1) begin
			if (verdict.hit || (verdict.free && !free_q)) begin
				fnd_addr_q <= addr_s1;
				fnd_page_q <= page_s1;
				fnd_off_q  <= off_s1;
				fnd_refs_q <= verdict.refs_inc;
			end
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SQ_CLR;
			clr_report_q <= 1'b0;
			scan_addr_q  <= '0;
			page_q       <= '0;
			off_q        <= '0;
			issue_q      <= 1'b0;
			vld_s1       <= 1'b0;
			open_q       <= '0;
			live_q       <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			res_status_q <= rgsc_pkg::ST_DONE;
			res_slot_q   <= '0;
			res_page_q   <= '0;
			res_off_q    <= '0;
			res_load_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			vld_s1 <= (state_q == SQ_SCAN) && issue_q;
			// Load the output register once it is free, else drop a taken result.
			if ((state_q == SQ_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tuser_q  <= res_status_q;
				m_tdata_q  <= {4'd0, rgsc_pkg::LIVEO_W'(live_q), res_load_q,
					res_has_tile ? rgsc_pkg::SLOTO_W'(res_slot_q) : rgsc_pkg::SLOTO_W'(0),
					res_has_tile ? tile_calc : rgsc_pkg::TILE_W'(0)};
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				// Zero every slot, one per cycle.
				SQ_CLR: begin
					scan_addr_q <= scan_addr_q + SW'(1);
					if (scan_addr_q == SW'(NSLOTS - 1)) begin
						open_q       <= '0;
						live_q       <= '0;
						res_status_q <= rgsc_pkg::ST_DONE;
						res_load_q   <= 1'b0;
						state_q      <= clr_report_q ? SQ_DONE : SQ_IDLE;
					end
				end
				// Take a request and route it.
				SQ_IDLE: begin
					res_load_q <= 1'b0;
					if (accept) begin
						case (in_req)
							rgsc_pkg::REQ_ALLOC: begin
								hit_q       <= 1'b0;
								free_q      <= 1'b0;
								scan_addr_q <= '0;
								page_q      <= '0;
								off_q       <= '0;
								issue_q     <= 1'b1;
								if (in_cp == '0) begin
									res_status_q <= rgsc_pkg::ST_UNMAPPED;
									state_q      <= SQ_DONE;
								end else if (open_q == '0) begin
									state_q <= SQ_ALLOC;
								end else begin
									state_q <= SQ_SCAN;
								end
							end
							rgsc_pkg::REQ_RELEASE: begin
								if (slot_in_range) begin
									state_q <= SQ_REL;
								end else begin
									res_status_q <= rgsc_pkg::ST_IGNORED;
									state_q      <= SQ_DONE;
								end
							end
							rgsc_pkg::REQ_CLEAR: begin
								scan_addr_q  <= '0;
								clr_report_q <= 1'b1;
								state_q      <= SQ_CLR;
							end
							default: begin
								res_status_q <= rgsc_pkg::ST_DONE;
								state_q      <= SQ_DONE;
							end
						endcase
					end
				end
				// Issue one slot per cycle and judge the slot read last cycle.
				SQ_SCAN: begin
					if (issue_q) begin
						scan_addr_q <= scan_addr_q + SW'(1);
						if (issue_wrap) begin
							off_q  <= '0;
							page_q <= page_q + PW'(1);
						end else begin
							off_q <= off_q + OW'(1);
						end
						if (issue_last) begin
							issue_q <= 1'b0;
						end
					end
					if (vld_s1) begin
						if (verdict.hit) begin
							hit_q   <= 1'b1;
							state_q <= SQ_ALLOC;
						end else begin
							if (verdict.free) begin
								free_q <= 1'b1;
							end
							if (last_s1) begin
								state_q <= SQ_ALLOC;
							end
						end
					end
				end
				// Decide the allocation; the memory write happens here.
				SQ_ALLOC: begin
					state_q <= SQ_DONE;
					if (hit_q) begin
						res_status_q <= rgsc_pkg::ST_HIT;
						res_slot_q   <= fnd_addr_q;
						res_page_q   <= fnd_page_q;
						res_off_q    <= fnd_off_q;
					end else if (free_q) begin
						if (mapped_q) begin
							res_status_q <= rgsc_pkg::ST_NEW;
							res_slot_q   <= fnd_addr_q;
							res_page_q   <= fnd_page_q;
							res_off_q    <= fnd_off_q;
							res_load_q   <= 1'b1;
							live_q       <= live_q + LW'(1);
						end else begin
							res_status_q <= rgsc_pkg::ST_UNMAPPED;
						end
					end else if (32'(open_q) >= MAX_PAGES) begin
						res_status_q <= rgsc_pkg::ST_NO_PAGE;
					end else if (!avail_q) begin
						res_status_q <= rgsc_pkg::ST_REFUSED;
					end else begin
						// The new page stays open even for an unmapped glyph.
						open_q <= open_q + PW'(1);
						if (mapped_q) begin
							res_status_q <= rgsc_pkg::ST_NEW;
							res_slot_q   <= scan_addr_q;
							res_page_q   <= open_q[PIW-1:0];
							res_off_q    <= '0;
							res_load_q   <= 1'b1;
							live_q       <= live_q + LW'(1);
						end else begin
							res_status_q <= rgsc_pkg::ST_UNMAPPED;
						end
					end
				end
				// Drop one reference; the slot is freed at zero.
				SQ_REL: begin
					state_q <= SQ_DONE;
					if (verdict.live) begin
						res_status_q <= rgsc_pkg::ST_DONE;
						if (verdict.last_ref && (live_q != '0)) begin
							live_q <= live_q - LW'(1);
						end
					end else begin
						res_status_q <= rgsc_pkg::ST_IGNORED;
					end
				end
				// Wait until the result has moved into the output register.
				SQ_DONE: begin
					if (out_free) begin
						state_q <= SQ_IDLE;
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- rtl/rgsc_ram.sv -----
// ----------------------------------------------------------------------------
// rgsc_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rgsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/rgsc_match.sv -----
// ----------------------------------------------------------------------------
// rgsc_match
// Shared slot compare unit: key match, free test and count update.
// ----------------------------------------------------------------------------
module rgsc_match (
	input  rgsc_pkg::entry_t              entry,
	input  logic [rgsc_pkg::KEY_W-1:0]    codepoint,
	output rgsc_pkg::match_t              verdict
);

	logic live;

	assign live = (entry.refs != '0);

	// A hit needs a live slot; the count saturates on increment.
	always_comb begin
		verdict.hit      = live && (entry.key == codepoint);
		verdict.free     = (entry.key == '0);
		verdict.live     = live;
		verdict.last_ref = (entry.refs == rgsc_pkg::REF_W'(1));
		verdict.refs_inc = (entry.refs == rgsc_pkg::REF_MAX) ? entry.refs
			: entry.refs + rgsc_pkg::REF_W'(1);
		verdict.refs_dec = entry.refs - rgsc_pkg::REF_W'(1);
	end

endmodule
